// ----- design/mcbrf_pkg.sv -----
// ----------------------------------------------------------------------------
// mcbrf_pkg
// Shared constants and types for the multi-channel byte ring FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package mcbrf_pkg;

   localparam int CHANNELS    = 4;
   localparam int MAX_DEPTH   = 64;
   localparam int STORE_DEPTH = CHANNELS * MAX_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // item field widths
   localparam int FUNC_W = 3;
   localparam int CHAN_W = 2;
   localparam int CNT_W  = 7;
   localparam int BYTE_W = 8;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   localparam logic [FUNC_W-1:0] FUNC_INIT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LEN  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PUT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_GET  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PEEK = 3'd4;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_EMIT  = 5'b00100,
      S_RADDR = 5'b01000,
      S_RDATA = 5'b10000
   } state_type;

endpackage

`default_nettype wire

// ----- design/mcbrf_ram.sv -----
// ----------------------------------------------------------------------------
// mcbrf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mcbrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/multi_channel_byte_ring_fifo_top.sv -----
// ----------------------------------------------------------------------------
// multi_channel_byte_ring_fifo_top
// Four byte FIFOs of programmable power-of-two size sharing one byte store.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on req_*: tuser carries the operation (init, length,
//   put, get, peek), tdata the channel, amount, byte and discard flag.
//   Results leave on rsp_*, one item per result, tlast on the final one.
//   Init, length, put and unknown operations give one result; get and peek
//   give one result per granted byte (one result when nothing is granted or
//   a get discards).
//   Sequencing: one item at a time. A single-result operation passes
//   through the exec and emit states; its result is registered as the
//   block returns to idle, so it is ready again when the result shows.
//   Get/peek pass through exec, then an address and a data state per
//   byte, set by the shared address unit and the store's registered read.
//   Reset clears all channel counters and sizes (every channel unset and
//   empty) and drops any pending result; store contents are not cleared.
//   A stalled receiver holds the result register and the sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_byte_ring_fifo_top
   import mcbrf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   // [1:0] channel, [8:2] amount, [16:9] data_byte, [17] no_buffer, rest 0
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [2:0] func
   input  wire logic [FUNC_W-1:0]      req_tuser,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [6:0] count, [14:7] out_byte, rest 0
   output      logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] status
   output      logic [0:0]             rsp_tuser,
   output      logic                   rsp_tlast
);

   state_type state_ff, state_in;

   // latched request
   logic [FUNC_W-1:0] func_ff;
   logic [CHAN_W-1:0] chan_ff;
   logic [CNT_W-1:0]  amount_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic              nobuf_ff;

   // per-channel state
   logic [CNT_W-1:0] wc_ff   [CHANNELS];
   logic [CNT_W-1:0] wc_in   [CHANNELS];
   logic [CNT_W-1:0] rc_ff   [CHANNELS];
   logic [CNT_W-1:0] rc_in   [CHANNELS];
   logic [CNT_W-1:0] size_ff [CHANNELS];
   logic [CNT_W-1:0] size_in [CHANNELS];

   // sequencer working registers
   logic [CNT_W-1:0] grant_ff, grant_in;
   logic [CNT_W-1:0] rbase_ff, rbase_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             pend_status_ff, pend_status_in;
   logic [CNT_W-1:0] pend_count_ff, pend_count_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_acc;
   logic              out_free;
   logic              valid_ch;
   logic [CH_W-1:0]   cidx;
   logic [CNT_W-1:0]  fill;
   logic [CNT_W-1:0]  size;
   logic [CNT_W-1:0]  ptr;
   logic [CNT_W-1:0]  off;
   logic [ADDR_W-1:0] mem_addr;
   logic              ram_we;
   logic [BYTE_W-1:0] ram_rdata;
   logic              init_ok;
   logic              put_ok;
   logic [CNT_W-1:0]  grant;
   logic              rd_last;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign valid_ch = (int'(chan_ff) < CHANNELS);
   assign cidx     = CH_W'(chan_ff);
   assign size     = valid_ch ? size_ff[cidx] : '0;
   assign fill     = valid_ch ? CNT_W'(wc_ff[cidx] - rc_ff[cidx]) : '0;

   // shared address unit: write pointer while executing, read walk otherwise
   assign ptr      = (state_ff == S_EXEC) ? wc_ff[cidx] : CNT_W'(rbase_ff + idx_ff);
   assign off      = (size == '0) ? '0 : (ptr & CNT_W'(size - CNT_W'(1)));
   assign mem_addr = ADDR_W'(ADDR_W'(cidx) * ADDR_W'(MAX_DEPTH) + ADDR_W'(off));

   assign init_ok = valid_ch && (amount_ff != '0)
                    && ((amount_ff & CNT_W'(amount_ff - CNT_W'(1))) == '0)
                    && (int'(amount_ff) <= MAX_DEPTH);
   assign put_ok  = valid_ch && (fill < size);

   always_comb begin
      grant = (amount_ff < fill) ? amount_ff : fill;
      if (int'(grant) > MAX_DEPTH) begin
         grant = CNT_W'(MAX_DEPTH);
      end
   end

   assign ram_we  = (state_ff == S_EXEC) && (func_ff == FUNC_PUT) && put_ok && !nobuf_ff;
   assign rd_last = (CNT_W'(idx_ff + CNT_W'(1)) == grant_ff);

   mcbrf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (mem_addr),
      .wr_data (byte_ff),
      .rd_addr (mem_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      wc_in          = wc_ff;
      rc_in          = rc_ff;
      size_in        = size_ff;
      grant_in       = grant_ff;
      rbase_in       = rbase_ff;
      idx_in         = idx_ff;
      pend_status_in = pend_status_ff;
      pend_count_in  = pend_count_ff;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            pend_status_in = 1'b0;
            pend_count_in  = '0;
            state_in       = S_EMIT;
            case (func_ff)
               FUNC_INIT: begin
                  pend_status_in = !init_ok;
                  if (init_ok) begin
                     size_in[cidx] = amount_ff;
                     wc_in[cidx]   = '0;
                     rc_in[cidx]   = '0;
                  end
               end
               FUNC_LEN: begin
                  pend_count_in = fill;
               end
               FUNC_PUT: begin
                  pend_status_in = !put_ok;
                  pend_count_in  = CNT_W'(put_ok);
                  if (put_ok) begin
                     wc_in[cidx] = CNT_W'(wc_ff[cidx] + CNT_W'(1));
                  end
               end
               FUNC_GET, FUNC_PEEK: begin
                  pend_count_in = grant;
                  grant_in      = grant;
                  rbase_in      = valid_ch ? rc_ff[cidx] : '0;
                  idx_in        = '0;
                  if (grant != '0 && !(func_ff == FUNC_GET && nobuf_ff)) begin
                     state_in = S_RADDR;
                  end
                  if (func_ff == FUNC_GET && valid_ch) begin
                     rc_in[cidx] = CNT_W'(rc_ff[cidx] + grant);
                  end
               end
               default: begin
               end
            endcase
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_count_in  = pend_count_ff;
               rsp_byte_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RADDR: begin
            state_in = S_RDATA;
         end
         S_RDATA: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               rsp_count_in  = grant_ff;
               rsp_byte_in   = ram_rdata;
               rsp_last_in   = rd_last;
               idx_in        = CNT_W'(idx_ff + CNT_W'(1));
               state_in      = rd_last ? S_IDLE : S_RADDR;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            wc_ff[i]   <= '0;
            rc_ff[i]   <= '0;
            size_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wc_ff        <= wc_in;
         rc_ff        <= rc_in;
         size_ff      <= size_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_acc) begin
         func_ff   <= req_tuser;
         chan_ff   <= req_tdata[1:0];
         amount_ff <= req_tdata[8:2];
         byte_ff   <= req_tdata[16:9];
         nobuf_ff  <= req_tdata[17];
      end
      grant_ff       <= grant_in;
      rbase_ff       <= rbase_in;
      idx_ff         <= idx_in;
      pend_status_ff <= pend_status_in;
      pend_count_ff  <= pend_count_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {1'b0, rsp_byte_ff, rsp_count_ff};
   assign rsp_tuser[0] = rsp_status_ff;
   assign rsp_tlast    = rsp_last_ff;

   // a channel never holds more than its configured size
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> (fill <= size))
      else $error("fill level above ring size");

   // the read walk never runs past the granted count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RADDR || state_ff == S_RDATA) |-> (idx_ff < grant_ff))
      else $error("read index beyond grant");

   // the final byte of a get/peek returns the sequencer to idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RDATA && out_free && rd_last) |=> (state_ff == S_IDLE && rsp_tlast))
      else $error("last byte did not close the operation");

   // the store is written only by an accepted put
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (func_ff == FUNC_PUT && fill < size && !nobuf_ff))
      else $error("store written outside put");

endmodule

`default_nettype wire
